/* design/utf8dc_pkg.sv */
`default_nettype none

package utf8dc_pkg;

  localparam int DEFAULT_OFFSET_BITS = 16;
  localparam int SCALAR_BITS         = 21;
  localparam int OUT_OFFSET_BITS     = 16;
  localparam int LENGTH_BITS         = 3;
  localparam int SCRIPT_BITS         = 4;
  localparam int BIDI_BITS           = 3;
  localparam int BREAK_BITS          = 4;
  localparam int ERROR_BITS          = 3;

  localparam logic [ERROR_BITS-1:0] ERR_OK         = 3'd0;
  localparam logic [ERROR_BITS-1:0] ERR_BAD_LEAD   = 3'd1;
  localparam logic [ERROR_BITS-1:0] ERR_TRUNCATED  = 3'd2;
  localparam logic [ERROR_BITS-1:0] ERR_BAD_CONT   = 3'd3;
  localparam logic [ERROR_BITS-1:0] ERR_NON_SCALAR = 3'd4;

  localparam logic [SCRIPT_BITS-1:0] SCRIPT_LATIN     = 4'd0;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_HEBREW    = 4'd1;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_ARABIC    = 4'd2;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_HIRAGANA  = 4'd3;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_KATAKANA  = 4'd4;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_HAN       = 4'd5;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_COMMON    = 4'd6;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_INHERITED = 4'd7;
  localparam logic [SCRIPT_BITS-1:0] SCRIPT_UNKNOWN   = 4'd8;

  localparam logic [BIDI_BITS-1:0] BIDI_MARK    = 3'd0;
  localparam logic [BIDI_BITS-1:0] BIDI_WS      = 3'd1;
  localparam logic [BIDI_BITS-1:0] BIDI_EN      = 3'd2;
  localparam logic [BIDI_BITS-1:0] BIDI_AN      = 3'd3;
  localparam logic [BIDI_BITS-1:0] BIDI_RTL     = 3'd4;
  localparam logic [BIDI_BITS-1:0] BIDI_AL      = 3'd5;
  localparam logic [BIDI_BITS-1:0] BIDI_LTR     = 3'd6;
  localparam logic [BIDI_BITS-1:0] BIDI_NEUTRAL = 3'd7;

  localparam logic [BREAK_BITS-1:0] BRK_MANDATORY = 4'd0;
  localparam logic [BREAK_BITS-1:0] BRK_SPACE     = 4'd1;
  localparam logic [BREAK_BITS-1:0] BRK_MARK      = 4'd2;
  localparam logic [BREAK_BITS-1:0] BRK_NUMERIC   = 4'd3;
  localparam logic [BREAK_BITS-1:0] BRK_IDEOGRAPH = 4'd4;
  localparam logic [BREAK_BITS-1:0] BRK_HYPHEN    = 4'd5;
  localparam logic [BREAK_BITS-1:0] BRK_OPEN      = 4'd6;
  localparam logic [BREAK_BITS-1:0] BRK_CLOSE     = 4'd7;
  localparam logic [BREAK_BITS-1:0] BRK_ALPHA     = 4'd8;

  typedef struct packed {
    logic [SCALAR_BITS-1:0]     value;
    logic [OUT_OFFSET_BITS-1:0] offset;
    logic [LENGTH_BITS-1:0]     length;
    logic [OUT_OFFSET_BITS-1:0] cluster;
    logic [ERROR_BITS-1:0]      err;
    logic                       last;
  } beat_t;

  function automatic logic between(logic [SCALAR_BITS-1:0] v, logic [SCALAR_BITS-1:0] lo,
                                   logic [SCALAR_BITS-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic is_mark(logic [SCALAR_BITS-1:0] v);
    return between(v, 21'h0300, 21'h036F) || between(v, 21'h1AB0, 21'h1AFF) ||
           between(v, 21'h1DC0, 21'h1DFF) || between(v, 21'h20D0, 21'h20FF) ||
           between(v, 21'hFE20, 21'hFE2F) || between(v, 21'h064B, 21'h065F) ||
           (v == 21'h0670);
  endfunction

endpackage

`default_nettype wire

/* design/utf8dc_in_if.sv */
`default_nettype none

interface utf8dc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

/* design/utf8dc_out_if.sv */
`default_nettype none

interface utf8dc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [utf8dc_pkg::SCALAR_BITS-1:0]     scalar_value;
  logic [utf8dc_pkg::OUT_OFFSET_BITS-1:0] byte_offset;
  logic [utf8dc_pkg::LENGTH_BITS-1:0]     byte_length;
  logic [utf8dc_pkg::SCRIPT_BITS-1:0]     script_class;
  logic [utf8dc_pkg::BIDI_BITS-1:0]       bidi_class;
  logic [utf8dc_pkg::BREAK_BITS-1:0]      break_class;
  logic [utf8dc_pkg::OUT_OFFSET_BITS-1:0] cluster_index;
  logic [utf8dc_pkg::ERROR_BITS-1:0]      error_code;
  logic                                  text_done;

  modport source (output valid, output scalar_value, output byte_offset, output byte_length,
                  output script_class, output bidi_class, output break_class,
                  output cluster_index, output error_code, output text_done, input ready);
  modport sink (input valid, input scalar_value, input byte_offset, input byte_length,
                input script_class, input bidi_class, input break_class,
                input cluster_index, input error_code, input text_done, output ready);
endinterface

`default_nettype wire

/* design/utf8dc_decode.sv */
`default_nettype none

module utf8dc_decode #(
  parameter int OFFSET_BITS = utf8dc_pkg::DEFAULT_OFFSET_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  utf8dc_in_if.sink          text,
  output utf8dc_pkg::beat_t  beat,
  output logic               beat_valid,
  input  wire logic          beat_ready
);

  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  logic [utf8dc_pkg::SCALAR_BITS-1:0] code_accumulator, acc_next, acc_shift, value;
  logic [1:0]                         bytes_remaining, rem_next;
  logic [utf8dc_pkg::LENGTH_BITS-1:0] sequence_length, len_next;
  logic                               bad_continuation_seen, bad_next;
  logic [OFFSET_BITS-1:0]             sequence_start, start_next;
  logic [OFFSET_BITS-1:0]             offset_counter, offset_next;
  logic [OFFSET_BITS-1:0]             cluster_counter, cluster_next;
  logic [OFFSET_BITS-1:0]             previous_cluster, prev_next;
  logic [OFFSET_BITS-1:0]             cl;
  logic                               any_scalar_seen, seen_next;
  logic                               error_halted, halted_next;
  utf8dc_pkg::beat_t                  beat_next;
  logic                               beat_valid_next;

  logic                               fire, last, multi, emit_ok, emit_err, clear, non_scalar;
  logic [7:0]                         b;
  logic [utf8dc_pkg::ERROR_BITS-1:0]  err_code;
  logic [31:0]                        start_wide, cl_wide;

  assign text.ready = !beat_valid || beat_ready;
  assign fire       = text.valid && text.ready;
  assign b          = text.data_byte;
  assign last       = text.end_of_text;
  assign acc_shift  = {code_accumulator[14:0], b[5:0]};

  assign non_scalar =
    ((sequence_length == 3'd2) && (acc_shift < 21'h80)) ||
    ((sequence_length == 3'd3) && (acc_shift < 21'h800)) ||
    ((sequence_length == 3'd4) && (acc_shift < 21'h10000)) ||
    (acc_shift > 21'h10FFFF) || utf8dc_pkg::between(acc_shift, 21'hD800, 21'hDFFF);

  always_comb begin
    acc_next        = code_accumulator;
    rem_next        = bytes_remaining;
    len_next        = sequence_length;
    bad_next        = bad_continuation_seen;
    start_next      = sequence_start;
    offset_next     = offset_counter;
    cluster_next    = cluster_counter;
    prev_next       = previous_cluster;
    seen_next       = any_scalar_seen;
    halted_next     = error_halted;
    multi           = 1'b0;
    emit_ok         = 1'b0;
    emit_err        = 1'b0;
    clear           = 1'b0;
    err_code        = utf8dc_pkg::ERR_OK;
    value           = acc_shift;
    cl              = cluster_counter;
    beat_next       = beat;
    beat_valid_next = beat_valid && !beat_ready;

    if (fire) begin
      if (offset_counter != COUNT_MAX) begin
        offset_next = offset_counter + 1'b1;
      end
      if (error_halted) begin
        clear = last;
      end else if (bytes_remaining == 2'd0) begin
        start_next = offset_counter;
        bad_next   = 1'b0;
        if (!b[7]) begin
          len_next = 3'd1;
          value    = utf8dc_pkg::SCALAR_BITS'(b);
          emit_ok  = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          len_next = 3'd2;
          acc_next = utf8dc_pkg::SCALAR_BITS'(b[4:0]);
          rem_next = 2'd1;
          multi    = 1'b1;
        end else if (b[7:4] == 4'b1110) begin
          len_next = 3'd3;
          acc_next = utf8dc_pkg::SCALAR_BITS'(b[3:0]);
          rem_next = 2'd2;
          multi    = 1'b1;
        end else if (b[7:3] == 5'b11110) begin
          len_next = 3'd4;
          acc_next = utf8dc_pkg::SCALAR_BITS'(b[2:0]);
          rem_next = 2'd3;
          multi    = 1'b1;
        end else begin
          len_next = 3'd1;
          emit_err = 1'b1;
          err_code = utf8dc_pkg::ERR_BAD_LEAD;
        end
        if (multi && last) begin
          rem_next = 2'd0;
          emit_err = 1'b1;
          err_code = utf8dc_pkg::ERR_TRUNCATED;
        end
      end else begin
        bad_next = bad_continuation_seen || (b[7:6] != 2'b10);
        acc_next = acc_shift;
        rem_next = bytes_remaining - 2'd1;
        if (rem_next != 2'd0) begin
          if (last) begin
            rem_next = 2'd0;
            emit_err = 1'b1;
            err_code = utf8dc_pkg::ERR_TRUNCATED;
          end
        end else if (bad_next) begin
          emit_err = 1'b1;
          err_code = utf8dc_pkg::ERR_BAD_CONT;
        end else if (non_scalar) begin
          emit_err = 1'b1;
          err_code = utf8dc_pkg::ERR_NON_SCALAR;
        end else begin
          emit_ok = 1'b1;
        end
      end
    end

    if (emit_ok) begin
      if (utf8dc_pkg::is_mark(value) && any_scalar_seen) begin
        cl = previous_cluster;
      end else begin
        cl = cluster_counter;
        if (cluster_counter != COUNT_MAX) begin
          cluster_next = cluster_counter + 1'b1;
        end
        prev_next = cluster_counter;
      end
      seen_next = 1'b1;
      rem_next  = 2'd0;
    end

    start_wide = 32'(start_next);
    cl_wide    = 32'(cl);

    if (emit_ok || emit_err) begin
      beat_valid_next = 1'b1;
      beat_next.value   = emit_ok ? value : '0;
      beat_next.offset  = start_wide[utf8dc_pkg::OUT_OFFSET_BITS-1:0];
      beat_next.length  = len_next;
      beat_next.cluster = emit_ok ? cl_wide[utf8dc_pkg::OUT_OFFSET_BITS-1:0] : '0;
      beat_next.err     = err_code;
      beat_next.last    = last;
      if (last) begin
        clear = 1'b1;
      end else if (emit_err) begin
        halted_next = 1'b1;
      end
    end

    if (clear) begin
      acc_next     = '0;
      rem_next     = '0;
      len_next     = '0;
      bad_next     = 1'b0;
      start_next   = '0;
      offset_next  = '0;
      cluster_next = '0;
      prev_next    = '0;
      seen_next    = 1'b0;
      halted_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accumulator      <= '0;
      bytes_remaining       <= '0;
      sequence_length       <= '0;
      bad_continuation_seen <= 1'b0;
      sequence_start        <= '0;
      offset_counter        <= '0;
      cluster_counter       <= '0;
      previous_cluster      <= '0;
      any_scalar_seen       <= 1'b0;
      error_halted          <= 1'b0;
      beat_valid            <= 1'b0;
    end else begin
      code_accumulator      <= acc_next;
      bytes_remaining       <= rem_next;
      sequence_length       <= len_next;
      bad_continuation_seen <= bad_next;
      sequence_start        <= start_next;
      offset_counter        <= offset_next;
      cluster_counter       <= cluster_next;
      previous_cluster      <= prev_next;
      any_scalar_seen       <= seen_next;
      error_halted          <= halted_next;
      beat_valid            <= beat_valid_next;
    end
    beat <= beat_next;
  end

`ifndef SYNTHESIS
  a_halted_no_pending: assert property (@(posedge clk) disable iff (rst)
    error_halted |-> (bytes_remaining == 2'd0))
    else $error("halted with a sequence still open");

  a_remaining_below_length: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining != 2'd0) |-> (sequence_length > utf8dc_pkg::LENGTH_BITS'(bytes_remaining)))
    else $error("remaining count not below sequence length");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && last) |=> ((offset_counter == '0) && !error_halted && (bytes_remaining == 2'd0)))
    else $error("end of text did not clear counters");

  a_bad_lead_length: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && (beat.err == utf8dc_pkg::ERR_BAD_LEAD)) |-> (beat.length == 3'd1))
    else $error("bad lead beat with length other than one");
`endif

endmodule

`default_nettype wire

/* design/utf8dc_classify.sv */
`default_nettype none

module utf8dc_classify (
  input  wire logic          clk,
  input  wire logic          rst,
  input  utf8dc_pkg::beat_t  beat,
  input  wire logic          beat_valid,
  output logic               beat_ready,
  utf8dc_out_if.source       result
);

  function automatic logic [utf8dc_pkg::SCRIPT_BITS-1:0] script_of(
    logic [utf8dc_pkg::SCALAR_BITS-1:0] v);
    if (utf8dc_pkg::is_mark(v)) return utf8dc_pkg::SCRIPT_INHERITED;
    if (utf8dc_pkg::between(v, 21'h41, 21'h5A) || utf8dc_pkg::between(v, 21'h61, 21'h7A) ||
        utf8dc_pkg::between(v, 21'hC0, 21'h24F)) return utf8dc_pkg::SCRIPT_LATIN;
    if (utf8dc_pkg::between(v, 21'h0590, 21'h05FF)) return utf8dc_pkg::SCRIPT_HEBREW;
    if (utf8dc_pkg::between(v, 21'h0600, 21'h06FF) || utf8dc_pkg::between(v, 21'h0750, 21'h077F) ||
        utf8dc_pkg::between(v, 21'h08A0, 21'h08FF) || utf8dc_pkg::between(v, 21'hFB50, 21'hFDFF) ||
        utf8dc_pkg::between(v, 21'hFE70, 21'hFEFF)) return utf8dc_pkg::SCRIPT_ARABIC;
    if (utf8dc_pkg::between(v, 21'h3040, 21'h309F)) return utf8dc_pkg::SCRIPT_HIRAGANA;
    if (utf8dc_pkg::between(v, 21'h30A0, 21'h30FF) || utf8dc_pkg::between(v, 21'h31F0, 21'h31FF))
      return utf8dc_pkg::SCRIPT_KATAKANA;
    if (utf8dc_pkg::between(v, 21'h3400, 21'h4DBF) || utf8dc_pkg::between(v, 21'h4E00, 21'h9FFF) ||
        utf8dc_pkg::between(v, 21'hF900, 21'hFAFF)) return utf8dc_pkg::SCRIPT_HAN;
    if ((v <= 21'h40) || utf8dc_pkg::between(v, 21'h2000, 21'h206F) ||
        utf8dc_pkg::between(v, 21'h3000, 21'h303F)) return utf8dc_pkg::SCRIPT_COMMON;
    return utf8dc_pkg::SCRIPT_UNKNOWN;
  endfunction

  function automatic logic [utf8dc_pkg::BIDI_BITS-1:0] bidi_of(
    logic [utf8dc_pkg::SCALAR_BITS-1:0] v, logic [utf8dc_pkg::SCRIPT_BITS-1:0] s);
    if (utf8dc_pkg::is_mark(v)) return utf8dc_pkg::BIDI_MARK;
    if ((v == 21'h09) || (v == 21'h0A) || (v == 21'h0D) || (v == 21'h20) || (v == 21'hA0))
      return utf8dc_pkg::BIDI_WS;
    if (utf8dc_pkg::between(v, 21'h30, 21'h39)) return utf8dc_pkg::BIDI_EN;
    if (utf8dc_pkg::between(v, 21'h0660, 21'h0669) || utf8dc_pkg::between(v, 21'h06F0, 21'h06F9))
      return utf8dc_pkg::BIDI_AN;
    if (utf8dc_pkg::between(v, 21'h0590, 21'h05FF)) return utf8dc_pkg::BIDI_RTL;
    if (s == utf8dc_pkg::SCRIPT_ARABIC) return utf8dc_pkg::BIDI_AL;
    if ((s == utf8dc_pkg::SCRIPT_LATIN) || (s == utf8dc_pkg::SCRIPT_HAN) ||
        (s == utf8dc_pkg::SCRIPT_HIRAGANA) || (s == utf8dc_pkg::SCRIPT_KATAKANA))
      return utf8dc_pkg::BIDI_LTR;
    return utf8dc_pkg::BIDI_NEUTRAL;
  endfunction

  function automatic logic [utf8dc_pkg::BREAK_BITS-1:0] break_of(
    logic [utf8dc_pkg::SCALAR_BITS-1:0] v, logic [utf8dc_pkg::SCRIPT_BITS-1:0] s);
    if ((v == 21'h0A) || (v == 21'h0D) || (v == 21'h2028) || (v == 21'h2029))
      return utf8dc_pkg::BRK_MANDATORY;
    if ((v == 21'h09) || (v == 21'h20) || (v == 21'hA0) || (v == 21'h3000))
      return utf8dc_pkg::BRK_SPACE;
    if (utf8dc_pkg::is_mark(v)) return utf8dc_pkg::BRK_MARK;
    if (utf8dc_pkg::between(v, 21'h30, 21'h39) || utf8dc_pkg::between(v, 21'h0660, 21'h0669) ||
        utf8dc_pkg::between(v, 21'h06F0, 21'h06F9)) return utf8dc_pkg::BRK_NUMERIC;
    if ((s == utf8dc_pkg::SCRIPT_HAN) || (s == utf8dc_pkg::SCRIPT_HIRAGANA) ||
        (s == utf8dc_pkg::SCRIPT_KATAKANA)) return utf8dc_pkg::BRK_IDEOGRAPH;
    if ((v == 21'h2D) || (v == 21'h2010) || (v == 21'h2013)) return utf8dc_pkg::BRK_HYPHEN;
    if ((v == 21'h28) || (v == 21'h5B) || (v == 21'h7B) || (v == 21'h3008) || (v == 21'h300C))
      return utf8dc_pkg::BRK_OPEN;
    if ((v == 21'h29) || (v == 21'h5D) || (v == 21'h7D) || (v == 21'h2C) || (v == 21'h2E) ||
        (v == 21'h3A) || (v == 21'h3B) || (v == 21'h3001) || (v == 21'h3002) ||
        (v == 21'h3009) || (v == 21'h300D)) return utf8dc_pkg::BRK_CLOSE;
    return utf8dc_pkg::BRK_ALPHA;
  endfunction

  logic                                valid;
  logic                                load;
  logic                                is_err;
  logic [utf8dc_pkg::SCRIPT_BITS-1:0]  script;

  assign beat_ready = !valid || result.ready;
  assign load       = beat_valid && beat_ready;
  assign is_err     = (beat.err != utf8dc_pkg::ERR_OK);
  assign script     = script_of(beat.value);

  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (beat_ready) begin
      valid <= beat_valid;
    end
    if (load) begin
      result.scalar_value  <= beat.value;
      result.byte_offset   <= beat.offset;
      result.byte_length   <= beat.length;
      result.cluster_index <= beat.cluster;
      result.error_code    <= beat.err;
      result.text_done     <= beat.last;
      result.script_class  <= is_err ? utf8dc_pkg::SCRIPT_UNKNOWN : script;
      result.bidi_class    <= is_err ? utf8dc_pkg::BIDI_NEUTRAL : bidi_of(beat.value, script);
      result.break_class   <= is_err ? utf8dc_pkg::BRK_ALPHA : break_of(beat.value, script);
    end
  end

endmodule

`default_nettype wire

/* design/utf8_decode_classify_core.sv */
`default_nettype none

// Streaming UTF-8 decoder: takes one byte per beat on text, with end_of_text on the last
// byte of each text, and gives one result beat per completed sequence (scalar, offset,
// length, script/bidi/break class, cluster number) or one error beat, after which bytes are
// dropped up to end of text. A byte is taken every cycle while results are drained; the
// decode state register and the classification result register form two stages: each
// result passes through the decode beat register and then the result register. Offset and
// cluster counters are OFFSET_BITS wide and saturate; the reported fields carry their low
// 16 bits. Nothing to clear after reset: the block takes bytes at once.
module utf8_decode_classify_core #(
  parameter int OFFSET_BITS = utf8dc_pkg::DEFAULT_OFFSET_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst,
  utf8dc_in_if.sink      text,
  utf8dc_out_if.source   result
);

  utf8dc_pkg::beat_t beat;
  logic              beat_valid;
  logic              beat_ready;

  utf8dc_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready)
  );

  utf8dc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .result     (result)
  );

endmodule

`default_nettype wire
